@@ rtl/baro_compensate_altitude_assert.svh @@
// Assertion macros shared by the checker of the altitude compensation block.
// Needs nothing but a clock and an active-low reset in the using scope.
`ifndef BARO_COMPENSATE_ALTITUDE_ASSERT_SVH
`define BARO_COMPENSATE_ALTITUDE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/baca_pkg.sv @@
// Shared constants, the altitude table and small helpers of the compensation block.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package baca_pkg;

	localparam int ALT_TABLE_ENTRIES = 167;
	localparam int ALT_IDX_LOW       = 61;
	localparam int ALT_IDX_HIGH      = ALT_IDX_LOW + ALT_TABLE_ENTRIES - 2;
	localparam int ALT_STEP_PA       = 500;
	localparam int ALT_BIAS          = 400000;
	localparam int DIV_STAGES        = 32;
	// 8 front stages, divider load plus its bit stages, 4 post stages, 6 altitude stages.
	localparam int PIPE_DEPTH        = 8 + DIV_STAGES + 1 + 4 + 6;

	// floor(n / 125) = (n * RECIP_125) >> 37 for n below 2**30.
	localparam logic [30:0] RECIP_125  = 31'd1099511628;
	localparam int          SHIFT_125  = 37;
	// floor(n / 500) = (n * RECIP_500) >> 38 for n below 2**30.
	localparam logic [29:0] RECIP_500  = 30'd549755814;
	localparam int          SHIFT_500  = 38;

	typedef enum logic [7:0] {
		REG_TEMP  = 8'd0,
		REG_PLOW  = 8'd1,
		REG_PHIGH = 8'd2,
		REG_P9    = 8'd3
	} cfg_reg_t;

	localparam int ALT_TABLE [ALT_TABLE_ENTRIES] = '{
		905437, 894505, 883715, 873062, 862543, 852155, 841893,
		831755, 821736, 811835, 802047, 792370, 782802, 773339,
		763979, 754720, 745558, 736493, 727521, 718641, 709850,
		701146, 692528, 683994, 675542, 667169, 658876, 650659,
		642517, 634449, 626453, 618528, 610673, 602885, 595165,
		587510, 579919, 572391, 564926, 557521, 550176, 542889,
		535660, 528488, 521371, 514309, 507301, 500346, 493442,
		486590, 479788, 473035, 466331, 459675, 453066, 446503,
		439986, 433514, 427086, 420702, 414361, 408062, 401804,
		395588, 389412, 383276, 377180, 371122, 365102, 359120,
		353175, 347267, 341395, 335558, 329757, 323990, 318258,
		312559, 306894, 301262, 295662, 290094, 284558, 279053,
		273579, 268135, 262722, 257338, 251984, 246658, 241362,
		236093, 230853, 225640, 220455, 215297, 210165, 205060,
		199981, 194927, 189899, 184897, 179919, 174966, 170038,
		165133, 160253, 155396, 150562, 145751, 140964, 136199,
		131456, 126735, 122037, 117360, 112704, 108070, 103457,
		98865, 94293, 89742, 85210, 80699, 76208, 71736,
		67284, 62851, 58437, 54042, 49665, 45307, 40968,
		36646, 32343, 28057, 23789, 19539, 15306, 11090,
		6891, 2709, -1456, -5605, -9737, -13853, -17953,
		-22036, -26104, -30156, -34193, -38214, -42220, -46211,
		-50186, -54147, -58092, -62023, -65940, -69842, -73730,
		-77603, -81463, -85308, -89140, -92957, -96761
	};

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		return 32'($signed(v) >>> n);
	endfunction

endpackage

@@ rtl/baca_ifs.sv @@
// Handshake channels of the compensation block: samples, results and register writes.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface baca_sample_if;
	logic        valid;
	logic        ready;
	logic [19:0] raw_pressure;
	logic [19:0] raw_temperature;
	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface baca_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] temperature_centi;
	logic        [31:0] pressure_pa;
	logic signed [20:0] altitude_cm;
	logic               valid_res;
	modport source (output valid, temperature_centi, pressure_pa, altitude_cm, valid_res,
		input ready);
	modport sink (input valid, temperature_centi, pressure_pa, altitude_cm, valid_res,
		output ready);
endinterface

interface baca_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_index;
	logic [63:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/baro_compensate_altitude.sv @@
// Throughput: one sample per cycle; the whole pipeline, including the 32-stage
// bit-per-stage pressure divider, advances together and holds while the output is blocked.
// Reset: arst_n clears the pipeline valid bits and all calibration registers to zero.
// Configuration writes are always accepted; cfg.ready is tied high.
// Top level: register file, compensation pipeline, divider and altitude table lookup.
// Depends on baca_pkg and the channel interfaces in baca_ifs.sv.
`timescale 1ns / 1ps

module baro_compensate_altitude
	import baca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	baca_sample_if.sink  sample,
	baca_result_if.source result,
	baca_cfg_if.sink     cfg
);

	logic [47:0] temp_q;
	logic [63:0] plow_q;
	logic [63:0] phigh_q;
	logic [15:0] p9_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q  <= '0;
			plow_q  <= '0;
			phigh_q <= '0;
			p9_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_TEMP:  temp_q  <= cfg.wdata[47:0];
				REG_PLOW:  plow_q  <= cfg.wdata;
				REG_PHIGH: phigh_q <= cfg.wdata;
				REG_P9:    p9_q    <= cfg.wdata[15:0];
				default: ;
			endcase
		end
	end

	logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = {16'd0, temp_q[15:0]};
	assign t2 = sx16(temp_q[31:16]);
	assign t3 = sx16(temp_q[47:32]);
	assign p1 = {16'd0, plow_q[15:0]};
	assign p2 = sx16(plow_q[31:16]);
	assign p3 = sx16(plow_q[47:32]);
	assign p4 = sx16(plow_q[63:48]);
	assign p5 = sx16(phigh_q[15:0]);
	assign p6 = sx16(phigh_q[31:16]);
	assign p7 = sx16(phigh_q[47:32]);
	assign p8 = sx16(phigh_q[63:48]);
	assign p9 = sx16(p9_q);

	logic [PIPE_DEPTH-1:0] vld_q;
	logic en;

	assign en = !vld_q[PIPE_DEPTH-1] || result.ready;
	assign sample.ready = en;
	assign result.valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], sample.valid};
		end
	end

	// Temperature and pressure coefficient stages.
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6, rp_s7;
	logic [31:0] m1_s1, dd_s1, v1_s2, m2_s2, tf_s3;
	logic [31:0] tc_s4, qq_s4, ap5_s4, p2a_s4;
	logic [31:0] tc_s5, b1_s5, ap5_s5, p2a_s5, p3q_s5;
	logic [31:0] tc_s6, b_s6, a2_s6;
	logic [31:0] tc_s7, b_s7, a3_s7;
	logic [31:0] tc_s8, a_s8, pp_s8;

	logic [31:0] d_c, a_c, q_c, b_c, pp_c;
	always_comb begin
		d_c  = {16'd0, sample.raw_temperature[19:4]} - t1;
		a_c  = asr(tf_s3, 1) - 32'd64000;
		q_c  = asr(a_c, 2);
		b_c  = asr(b1_s5 + {ap5_s5[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
		pp_c = 32'(((32'd1048576 - {12'd0, rp_s7}) - asr(b_s7, 12)) * 32'd3125);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s1  <= sample.raw_pressure;
			m1_s1  <= 32'(({15'd0, sample.raw_temperature[19:3]} - {t1[30:0], 1'b0}) * t2);
			dd_s1  <= 32'(d_c * d_c);

			rp_s2  <= rp_s1;
			v1_s2  <= asr(m1_s1, 11);
			m2_s2  <= 32'(asr(dd_s1, 12) * t3);

			rp_s3  <= rp_s2;
			tf_s3  <= v1_s2 + asr(m2_s2, 14);

			rp_s4  <= rp_s3;
			tc_s4  <= asr(32'(tf_s3 * 32'd5 + 32'd128), 8);
			qq_s4  <= 32'(q_c * q_c);
			ap5_s4 <= 32'(a_c * p5);
			p2a_s4 <= 32'(p2 * a_c);

			rp_s5  <= rp_s4;
			tc_s5  <= tc_s4;
			b1_s5  <= 32'(asr(qq_s4, 11) * p6);
			ap5_s5 <= ap5_s4;
			p2a_s5 <= p2a_s4;
			p3q_s5 <= 32'(p3 * asr(qq_s4, 13));

			rp_s6  <= rp_s5;
			tc_s6  <= tc_s5;
			b_s6   <= b_c;
			a2_s6  <= asr(asr(p3q_s5, 3) + asr(p2a_s5, 1), 18);

			rp_s7  <= rp_s6;
			tc_s7  <= tc_s6;
			b_s7   <= b_s6;
			a3_s7  <= 32'((32'd32768 + a2_s6) * p1);

			tc_s8  <= tc_s7;
			a_s8   <= asr(a3_s7, 15);
			pp_s8  <= pp_c;
		end
	end

	// Restoring divider, one quotient bit per stage. Entry 0 is the load stage.
	logic [31:0] drem_sd [DIV_STAGES+1];
	logic [31:0] dquo_sd [DIV_STAGES+1];
	logic [31:0] ddiv_sd [DIV_STAGES+1];
	logic [31:0] dtc_sd  [DIV_STAGES+1];
	logic        dz_sd   [DIV_STAGES+1];
	logic        dbig_sd [DIV_STAGES+1];

	logic [32:0] trial_c [DIV_STAGES];
	logic        ge_c    [DIV_STAGES];
	logic [31:0] nrem_c  [DIV_STAGES];

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			trial_c[k] = {drem_sd[k], dquo_sd[k][31]};
			ge_c[k]    = trial_c[k] >= {1'b0, ddiv_sd[k]};
			nrem_c[k]  = ge_c[k] ? 32'(trial_c[k] - {1'b0, ddiv_sd[k]}) : trial_c[k][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Large dividends are divided unshifted and doubled afterwards.
			drem_sd[0] <= '0;
			dquo_sd[0] <= pp_s8[31] ? pp_s8 : {pp_s8[30:0], 1'b0};
			ddiv_sd[0] <= a_s8;
			dtc_sd[0]  <= tc_s8;
			dz_sd[0]   <= a_s8 == 32'd0;
			dbig_sd[0] <= pp_s8[31];
			for (int k = 0; k < DIV_STAGES; k++) begin
				drem_sd[k+1] <= nrem_c[k];
				dquo_sd[k+1] <= {dquo_sd[k][30:0], ge_c[k]};
				ddiv_sd[k+1] <= ddiv_sd[k];
				dtc_sd[k+1]  <= dtc_sd[k];
				dz_sd[k+1]   <= dz_sd[k];
				dbig_sd[k+1] <= dbig_sd[k];
			end
		end
	end

	// Pressure correction stages.
	logic [31:0] tc_p1, tc_p2, tc_p3, tc_p4;
	logic        z_p1, z_p2, z_p3, z_p4;
	logic [31:0] p_p1, p_p2, p_p3, p_p4;
	logic [31:0] ss_p2, x_p2, wm_p3, x_p3;
	logic [31:0] s_c;

	assign s_c = {3'd0, p_p1[31:3]};

	always_ff @(posedge clk) begin
		if (en) begin
			tc_p1 <= dtc_sd[DIV_STAGES];
			z_p1  <= dz_sd[DIV_STAGES];
			p_p1  <= dbig_sd[DIV_STAGES] ? {dquo_sd[DIV_STAGES][30:0], 1'b0}
				: dquo_sd[DIV_STAGES];

			tc_p2 <= tc_p1;
			z_p2  <= z_p1;
			p_p2  <= p_p1;
			ss_p2 <= 32'(s_c * s_c);
			x_p2  <= 32'({2'd0, p_p1[31:2]} * p8);

			tc_p3 <= tc_p2;
			z_p3  <= z_p2;
			p_p3  <= p_p2;
			wm_p3 <= 32'(p9 * {13'd0, ss_p2[31:13]});
			x_p3  <= x_p2;

			tc_p4 <= tc_p3;
			z_p4  <= z_p3;
			p_p4  <= p_p3 + asr(asr(wm_p3, 12) + asr(x_p3, 13) + p7, 4);
		end
	end

	// Altitude lookup: split the pressure by the table step, then interpolate.
	logic [31:0] tc_a1, tc_a2, tc_a3, tc_a4, tc_a5;
	logic        z_a1, z_a2, z_a3, z_a4, z_a5;
	logic [31:0] p_a1, p_a2, p_a3, p_a4, p_a5;
	logic [60:0] prod_a1;
	logic [8:0]  rem_a2, rem_a3;
	logic [7:0]  idx_a2;
	logic signed [20:0] ta_a3, tb_a3;
	logic [29:0] num_a4;
	logic [59:0] prod_a5;

	logic [23:0] qt_c;
	logic [31:0] rem_c;
	logic [7:0]  idx_c;
	logic signed [31:0] num_c;
	logic [21:0] qa_c;

	always_comb begin
		qt_c  = prod_a1[SHIFT_125 +: 24];
		rem_c = p_a1 - 32'(qt_c * 32'(ALT_STEP_PA));
		priority if (qt_c < 24'(ALT_IDX_LOW)) begin
			idx_c = '0;
		end else if (qt_c > 24'(ALT_IDX_HIGH)) begin
			idx_c = 8'(ALT_IDX_HIGH - ALT_IDX_LOW);
		end else begin
			idx_c = 8'(qt_c - 24'(ALT_IDX_LOW));
		end
		// The bias keeps the sum positive so the floor division is unsigned.
		num_c = 32'(32'(ta_a3) * $signed({23'd0, 9'(ALT_STEP_PA) - rem_a3}))
			+ 32'(32'(tb_a3) * $signed({23'd0, rem_a3}))
			+ 32'sd25000 + 32'(ALT_STEP_PA * ALT_BIAS);
		qa_c  = prod_a5[SHIFT_500 +: 22];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tc_a1   <= tc_p4;
			z_a1    <= z_p4;
			p_a1    <= p_p4;
			prod_a1 <= p_p4[31:2] * RECIP_125;

			tc_a2   <= tc_a1;
			z_a2    <= z_a1;
			p_a2    <= p_a1;
			rem_a2  <= rem_c[8:0];
			idx_a2  <= idx_c;

			tc_a3   <= tc_a2;
			z_a3    <= z_a2;
			p_a3    <= p_a2;
			rem_a3  <= rem_a2;
			ta_a3   <= 21'(ALT_TABLE[idx_a2]);
			tb_a3   <= 21'(ALT_TABLE[8'(idx_a2 + 8'd1)]);

			tc_a4   <= tc_a3;
			z_a4    <= z_a3;
			p_a4    <= p_a3;
			num_a4  <= num_c[29:0];

			tc_a5   <= tc_a4;
			z_a5    <= z_a4;
			p_a5    <= p_a4;
			prod_a5 <= num_a4 * RECIP_500;

			result.temperature_centi <= z_a5 ? '0 : $signed(tc_a5);
			result.pressure_pa       <= z_a5 ? '0 : p_a5;
			result.altitude_cm       <= z_a5 ? '0 : $signed(21'(qa_c - 22'(ALT_BIAS)));
			result.valid_res         <= !z_a5;
		end
	end

endmodule

@@ rtl/baca_checker.sv @@
// Port-level checks on the altitude compensation block, bound to its top level.
// Depends on the macros in baro_compensate_altitude_assert.svh.
`timescale 1ns / 1ps
`include "baro_compensate_altitude_assert.svh"

module baca_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_temp,
	input logic        [31:0] out_press,
	input logic signed [20:0] out_alt,
	input logic               out_vres
);

	// A held result beat keeps its payload.
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_temp) && $stable(out_press) && $stable(out_alt) && $stable(out_vres))

	// A zero divisor clears every other field.
	`ASSERT_IMPLIES(a_zero, clk, arst_n, out_valid && !out_vres, out_temp == 32'sd0 && out_press == 32'd0 && out_alt == 21'sd0)

	// Samples are refused only while a finished result is blocked.
	`ASSERT_IMPLIES(a_stall, clk, arst_n, !in_ready, out_valid && !out_ready)

endmodule

bind baro_compensate_altitude baca_checker u_baca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_temp  (result.temperature_centi),
	.out_press (result.pressure_pa),
	.out_alt   (result.altitude_cm),
	.out_vres  (result.valid_res)
);
